// ===== design/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpm_pkg
// Types and constants shared by the longest prefix route lookup unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

  // Item kinds
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  localparam int unsigned CNT_W = 9;  // entry_count register width

  // Input beat
  typedef struct packed {
    logic        kind;
    logic [7:0]  entry_index;
    logic [31:0] route_prefix;
    logic [31:0] route_mask;
    logic [31:0] route_next_hop;
    logic [7:0]  route_port;
    logic [31:0] dest_addr;
  } lpm_in_t;

  // Result beat
  typedef struct packed {
    logic        hit;
    logic [7:0]  match_index;
    logic [31:0] hop_out;
    logic [7:0]  port_out;
  } lpm_out_t;

  // Match key memory word
  typedef struct packed {
    logic [31:0] prefix;
    logic [31:0] mask;
  } lpm_key_t;

  // Route data memory word
  typedef struct packed {
    logic [31:0] hop;
    logic [7:0]  port;
  } lpm_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_RESP
  } lpm_state_t;

endpackage

`default_nettype wire

// ===== design/lpm_ram.sv =====
// ----------------------------------------------------------------------------
// lpm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/longest_prefix_route_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// Linear route table with longest-mask matching over the first entry_count
// slots.
// ----------------------------------------------------------------------------
// A write beat stores one route and gives no result; busy stays low. A
// lookup beat holds busy high while the key memory is scanned one slot
// per cycle through its single read port, then the route data of the
// winner is read in ST_FETCH and the result is registered from ST_RESP
// (entry_count saturated to TABLE_ENTRIES; when it is zero the scan and
// fetch are skipped), and the block takes its next beat on the cycle the
// strobe shows. Each result is on out_data for exactly one cycle with
// out_valid high and is never held back.
// Slots that were never written must not be searched.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_prefix_route_lookup_unit
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  // command
  input  wire logic             start,
  output logic                  busy,
  input  wire lpm_in_t          in_data,
  // result
  output logic                  out_valid,
  output lpm_out_t              out_data,
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  lpm_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] entry_count_r;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [31:0]      dest_r;
  logic [CNT_W-1:0] iss_r;
  logic             cmp_v_r;
  logic [7:0]       cmp_idx_r;
  logic             found_r;
  logic [7:0]       best_idx_r;
  logic [31:0]      best_mask_r;
  logic             out_valid_r;
  lpm_out_t         out_data_r;

  logic             accept, acc_write, acc_lookup, wr_in_range;
  logic             issue, scan_done, fetch_en, resp_en;
  logic             match, better;
  logic [63:0]      key_rdata;
  logic [39:0]      data_rdata;
  lpm_key_t         key_rd;
  lpm_data_t        data_rd;
  lpm_key_t         key_wr;
  lpm_data_t        data_wr;

  // handshakes
  assign accept      = start && !busy;
  assign acc_write   = accept && (in_data.kind == KIND_WRITE);
  assign acc_lookup  = accept && (in_data.kind == KIND_LOOKUP);
  assign wr_in_range = 32'(in_data.entry_index) < TABLE_ENTRIES;
  assign cfg_ready   = 1'b1;

  // search limit, saturated to table depth
  assign limit_nxt = (32'(entry_count_r) > TABLE_ENTRIES) ? CNT_W'(TABLE_ENTRIES)
                                                          : entry_count_r;

  // memories
  assign key_wr  = '{prefix: in_data.route_prefix, mask: in_data.route_mask};
  assign data_wr = '{hop: in_data.route_next_hop, port: in_data.route_port};
  assign key_rd  = lpm_key_t'(key_rdata);
  assign data_rd = lpm_data_t'(data_rdata);

  lpm_ram #(.WIDTH(64), .DEPTH(TABLE_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (acc_write && wr_in_range),
    .waddr (AW'(in_data.entry_index)),
    .wdata (64'(key_wr)),
    .re    (issue),
    .raddr (AW'(iss_r)),
    .rdata (key_rdata)
  );

  lpm_ram #(.WIDTH(40), .DEPTH(TABLE_ENTRIES)) u_data_ram (
    .clk   (clk),
    .we    (acc_write && wr_in_range),
    .waddr (AW'(in_data.entry_index)),
    .wdata (40'(data_wr)),
    .re    (fetch_en),
    .raddr (AW'(best_idx_r)),
    .rdata (data_rdata)
  );

  // compare stage on the registered key word
  assign match     = (dest_r & key_rd.mask) == key_rd.prefix;
  assign better    = cmp_v_r && match && (!found_r || (key_rd.mask > best_mask_r));
  assign scan_done = cmp_v_r && ((CNT_W'(cmp_idx_r) + CNT_W'(1)) == limit_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_lookup) begin
          state_nxt = (limit_nxt == '0) ? ST_RESP : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_RESP;
      ST_RESP:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy     = 1'b1;
    issue    = 1'b0;
    fetch_en = 1'b0;
    resp_en  = 1'b0;
    case (state_r)
      ST_IDLE:  busy     = 1'b0;
      ST_SCAN:  issue    = iss_r < limit_r;
      ST_FETCH: fetch_en = 1'b1;
      ST_RESP:  resp_en  = 1'b1;
      default:  busy     = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      cmp_v_r       <= 1'b0;
      found_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= resp_en;
      cmp_v_r     <= issue;
      if (cfg_valid && cfg_ready) begin
        entry_count_r <= cfg_data;
      end
      if (acc_lookup) begin
        found_r <= 1'b0;
      end else if (better) begin
        found_r <= 1'b1;
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (acc_lookup) begin
      dest_r  <= in_data.dest_addr;
      limit_r <= limit_nxt;
      iss_r   <= '0;
    end else if (issue) begin
      iss_r <= iss_r + CNT_W'(1);
    end
    cmp_idx_r <= iss_r[7:0];
    if (better) begin
      best_idx_r  <= cmp_idx_r;
      best_mask_r <= key_rd.mask;
    end
  end

  // result register, zero fields on a miss
  always_ff @(posedge clk) begin
    if (resp_en) begin
      out_data_r.hit         <= found_r;
      out_data_r.match_index <= found_r ? best_idx_r : 8'd0;
      out_data_r.hop_out     <= found_r ? data_rd.hop : 32'd0;
      out_data_r.port_out    <= found_r ? data_rd.port : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_strobe_after_resp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_RESP))
    else $error("result strobe without response state");

  a_issue_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (iss_r <= limit_r))
    else $error("scan issued beyond limit");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.hit) |->
      (out_data_r.match_index == 8'd0 && out_data_r.hop_out == 32'd0 &&
       out_data_r.port_out == 8'd0))
    else $error("miss result carries non-zero fields");

  a_best_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (found_r && state_r != ST_IDLE) |-> (CNT_W'(best_idx_r) < limit_r))
    else $error("best slot outside searched range");

endmodule

`default_nettype wire
